[sv/modulated_pwm_compare_engine_top_macros.svh]
// Assertion macros shared by the compare engine modules
`ifndef MODULATED_PWM_COMPARE_ENGINE_TOP_MACROS_SVH
`define MODULATED_PWM_COMPARE_ENGINE_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MPWM_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("mpwm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MPWM_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("mpwm assertion failed");

`endif

[sv/mpwm_pkg.sv]
// Types, register map and constants for the modulated PWM compare engine
package mpwm_pkg;

    localparam int FIFO_DEPTH_DEF = 8192;
    localparam int LEVEL_W_DEF    = $clog2(FIFO_DEPTH_DEF + 1);

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_DUTY   = 2'd1;
    localparam logic [1:0] REG_MULT   = 2'd2;
    localparam logic [1:0] REG_SHIFT  = 2'd3;

    localparam logic [15:0] PERIOD_RST = 16'd65535;
    localparam logic [15:0] DUTY_RST   = 16'd0;
    localparam logic [7:0]  MULT_RST   = 8'd157;
    localparam logic [3:0]  SHIFT_RST  = 4'd7;

    // Derived values for the reset register contents
    localparam int ROUND_ADD = 65536;
    localparam int THR_SHIFT = 17;
    localparam int CENTER_BYTE = 127;
    localparam logic [15:0] THR_RST =
        16'(((int'(DUTY_RST) * int'(PERIOD_RST)) + ROUND_ADD) >> THR_SHIFT);
    localparam logic [14:0] CM_RST =
        15'((CENTER_BYTE * int'(MULT_RST)) >> int'(SHIFT_RST));

    // Input actions
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Update of the held compare pair
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_THRESH = 2'd2;

    typedef struct packed {
        logic [1:0] op;
        logic       playing;
        logic       faulty;
        logic       accepted;
    } mpwm_info_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mpwm_fifo_stat_t;

endpackage

[sv/mpwm_if.sv]
// Request and result channel interfaces of the compare engine
interface mpwm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] sample;
    logic [7:0] fault_bits;

    modport source (output valid, action, sample, fault_bits, input ready);
    modport sink   (input valid, action, sample, fault_bits, output ready);
endinterface

interface mpwm_out_if import mpwm_pkg::*; #(
    parameter int LEVEL_W = LEVEL_W_DEF
);
    logic               valid;
    logic               ready;
    logic [15:0]        compare_low;
    logic [15:0]        compare_high;
    logic               modulating;
    logic               faulty;
    logic               accepted;
    logic [LEVEL_W-1:0] fifo_level;

    modport source (output valid, compare_low, compare_high, modulating, faulty,
                    accepted, fifo_level, input ready);
    modport sink   (input valid, compare_low, compare_high, modulating, faulty,
                    accepted, fifo_level, output ready);
endinterface

[sv/modulated_pwm_compare_engine_top.sv]
// Modulated PWM compare engine: one result per request, passed through the request register
// and then the result register once the request is accepted, one request per clock sustained
// while the result side accepts. The request register holds the decoded request while the FIFO
// read register holds the popped byte; gain, center, clamp and the compare pair are formed
// between them and the result register. The FIFO memory has one write and one registered read
// port, and at most one of them is used per request. Threshold and center are derived from the
// configuration registers and settle in the cycle after a register write.
`include "modulated_pwm_compare_engine_top_macros.svh"

module modulated_pwm_compare_engine_top import mpwm_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    mpwm_in_if.sink            in_ch,
    mpwm_out_if.source         out_ch
);

    localparam int LEVEL_W = $clog2(FIFO_DEPTH + 1);

    // Configuration registers
    logic [15:0] period_reg;
    logic [15:0] duty_reg;
    logic [7:0]  mult_reg;
    logic [3:0]  shift_reg;
    logic [1:0]  reg_idx;
    logic        cfg_we;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_we  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            duty_reg   <= DUTY_RST;
            mult_reg   <= MULT_RST;
            shift_reg  <= SHIFT_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                REG_PERIOD: period_reg <= pwdata[15:0];
                REG_DUTY:   duty_reg   <= pwdata[15:0];
                REG_MULT:   mult_reg   <= pwdata[7:0];
                REG_SHIFT:  shift_reg  <= pwdata[3:0];
                default:    period_reg <= period_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_PERIOD: prdata = {16'd0, period_reg};
            REG_DUTY:   prdata = {16'd0, duty_reg};
            REG_MULT:   prdata = {24'd0, mult_reg};
            REG_SHIFT:  prdata = {28'd0, shift_reg};
            default:    prdata = '0;
        endcase
    end

    // Derived threshold and center
    logic [31:0]        duty_prod;
    logic [32:0]        duty_round;
    logic [14:0]        cm_full;
    logic [14:0]        cm_shift;
    logic [15:0]        thr_reg;
    logic signed [16:0] center_reg;
    logic [15:0]        thr_high;

    assign duty_prod  = 32'(duty_reg) * 32'(period_reg);
    assign duty_round = 33'(duty_prod) + 33'(ROUND_ADD);
    // 127 * m as (m << 7) - m
    assign cm_full    = {mult_reg, 7'd0} - 15'(mult_reg);
    assign cm_shift   = cm_full >> shift_reg;
    assign thr_high   = period_reg - thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_RST;
            center_reg <= $signed({1'b0, THR_RST}) - $signed({2'b00, CM_RST});
        end
        else
        begin
            thr_reg    <= duty_round[32:17];
            center_reg <= $signed({1'b0, duty_round[32:17]}) - $signed({2'b00, cm_shift});
        end
    end

    // Request decode and control state
    logic               in_acc;
    logic               is_write;
    logic               is_tick;
    logic               is_set;
    logic               is_clear;
    logic               push;
    logic               pop;
    logic [7:0]         flags_reg;
    logic [7:0]         flags_next;
    logic               playing_reg;
    logic               playing_next;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] level_after;
    logic [7:0]         rd_data;
    mpwm_fifo_stat_t    fstat;
    mpwm_info_t         info_next;

    logic               s0_valid_reg;
    logic               out_valid_reg;
    logic               s0_free;
    logic               s2_free;

    assign s2_free = !out_valid_reg | out_ch.ready;
    assign s0_free = !s0_valid_reg | s2_free;
    assign in_ch.ready = s0_free;
    assign in_acc = in_ch.valid & s0_free;

    assign is_write = (in_ch.action == ACT_WRITE);
    assign is_tick  = (in_ch.action == ACT_TICK);
    assign is_set   = (in_ch.action == ACT_SET);
    assign is_clear = (in_ch.action == ACT_CLEAR);
    assign push     = in_acc & is_write & !fstat.full;
    assign pop      = in_acc & is_tick & !fstat.empty;

    mpwm_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .wr_data (in_ch.sample),
        .rd_data (rd_data),
        .level   (level),
        .stat    (fstat)
    );

    always_comb
    begin
        flags_next   = flags_reg;
        playing_next = playing_reg;
        level_after  = level;
        info_next.op = OP_NONE;
        if (is_set)
        begin
            flags_next = flags_reg | in_ch.fault_bits;
        end
        else if (is_clear)
        begin
            flags_next = flags_reg & ~in_ch.fault_bits;
        end
        if (push)
        begin
            playing_next = 1'b1;
            level_after  = level + 1'b1;
        end
        else if (is_tick)
        begin
            playing_next = !fstat.empty;
            if (fstat.empty)
            begin
                info_next.op = OP_THRESH;
            end
            else
            begin
                info_next.op = OP_SAMPLE;
                level_after  = level - 1'b1;
            end
        end
        else if (is_clear && (flags_reg != '0) && (flags_next == '0))
        begin
            info_next.op = OP_THRESH;
        end
        info_next.playing  = playing_next;
        info_next.faulty   = (flags_next != '0);
        info_next.accepted = !(is_write & fstat.full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg   <= '0;
            playing_reg <= 1'b0;
        end
        else if (in_acc)
        begin
            flags_reg   <= flags_next;
            playing_reg <= playing_next;
        end
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s0_free)
            begin
                s0_valid_reg <= in_acc;
            end
            if (s2_free)
            begin
                out_valid_reg <= s0_valid_reg;
            end
        end
    end

    // Request register (popped byte sits in the FIFO read register)
    mpwm_info_t         s0_info_reg;
    logic [LEVEL_W-1:0] s0_level_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s0_info_reg  <= info_next;
            s0_level_reg <= level_after;
        end
    end

    // Gain, center, clamp and compare pair
    logic [15:0]        gain_prod;
    logic [15:0]        samp_scaled;
    logic signed [17:0] samp_sum;
    logic [14:0]        half_period;
    logic [15:0]        samp_low;
    logic [15:0]        samp_high;
    logic [15:0]        held_low_reg;
    logic [15:0]        held_high_reg;
    logic [15:0]        held_low_next;
    logic [15:0]        held_high_next;
    logic [15:0]        cmp_low;
    logic [15:0]        cmp_high;
    logic               s2_load;

    assign gain_prod   = 16'(rd_data) * 16'(mult_reg);
    assign samp_scaled = gain_prod >> shift_reg;
    assign s2_load     = s0_valid_reg & s2_free;
    assign half_period = period_reg[15:1];
    assign samp_sum    = $signed({2'b00, samp_scaled}) + 18'(center_reg);

    always_comb
    begin
        if (samp_sum < 0)
        begin
            samp_low = '0;
        end
        else if (samp_sum > $signed({3'b000, half_period}))
        begin
            samp_low = {1'b0, half_period};
        end
        else
        begin
            samp_low = samp_sum[15:0];
        end
        samp_high = period_reg - samp_low;

        case (s0_info_reg.op)
            OP_SAMPLE:
            begin
                held_low_next  = samp_low;
                held_high_next = samp_high;
            end
            OP_THRESH:
            begin
                held_low_next  = thr_reg;
                held_high_next = thr_high;
            end
            default:
            begin
                held_low_next  = held_low_reg;
                held_high_next = held_high_reg;
            end
        endcase

        if (s0_info_reg.faulty)
        begin
            cmp_low  = '0;
            cmp_high = '0;
        end
        else if (s0_info_reg.playing)
        begin
            cmp_low  = held_low_next;
            cmp_high = held_high_next;
        end
        else
        begin
            cmp_low  = thr_reg;
            cmp_high = thr_high;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_low_reg  <= '0;
            held_high_reg <= '0;
        end
        else if (s2_load)
        begin
            held_low_reg  <= held_low_next;
            held_high_reg <= held_high_next;
        end
    end

    logic [15:0]        out_low_reg;
    logic [15:0]        out_high_reg;
    mpwm_info_t         out_info_reg;
    logic [LEVEL_W-1:0] out_level_reg;

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            out_low_reg   <= cmp_low;
            out_high_reg  <= cmp_high;
            out_info_reg  <= s0_info_reg;
            out_level_reg <= s0_level_reg;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.compare_low  = out_low_reg;
    assign out_ch.compare_high = out_high_reg;
    assign out_ch.modulating   = out_info_reg.playing;
    assign out_ch.faulty       = out_info_reg.faulty;
    assign out_ch.accepted     = out_info_reg.accepted;
    assign out_ch.fifo_level   = out_level_reg;

    `MPWM_ASSERT_IMP(a_fault_zero, clk, rst_n, out_valid_reg && out_info_reg.faulty,
        out_low_reg == '0 && out_high_reg == '0)
    `MPWM_ASSERT_IMP(a_level_playing, clk, rst_n, out_valid_reg && out_level_reg != '0,
        out_info_reg.playing)
    `MPWM_ASSERT_NEXT(a_pop_sample, clk, rst_n, pop,
        s0_valid_reg && s0_info_reg.op == OP_SAMPLE)
    `MPWM_ASSERT_IMP(a_idle_empty, clk, rst_n, !playing_reg, fstat.empty)

endmodule

[sv/mpwm_fifo.sv]
// Sample byte FIFO with one write port and a registered read port
`include "modulated_pwm_compare_engine_top_macros.svh"

module mpwm_fifo import mpwm_pkg::*; #(
    parameter int DEPTH = FIFO_DEPTH_DEF,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic             pop,
    input  logic [7:0]       wr_data,
    output logic [7:0]       rd_data,
    output logic [CNT_W-1:0] level,
    output mpwm_fifo_stat_t  stat
);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Hold the popped byte until the next pop
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign rd_data    = rd_data_reg;
    assign level      = count_reg;
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    `MPWM_ASSERT_IMP(a_level_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `MPWM_ASSERT_IMP(a_push_not_full, clk, rst_n, push, !stat.full && !pop)
    `MPWM_ASSERT_NEXT(a_push_count, clk, rst_n, push, count_reg == $past(count_reg) + 1'b1)
    `MPWM_ASSERT_NEXT(a_pop_count, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

[verif/mpwm_compare_checker.sv]
// Watches the request, result and register channels and checks every result against a prediction
`timescale 1ns / 1ps

module mpwm_compare_checker import mpwm_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    mpwm_in_if                in_ch,
    mpwm_out_if               out_ch,
    output int                errors,
    output int                pending,
    output int                checked
);

    localparam int PTR_W      = $clog2(FIFO_DEPTH_DEF);

    typedef struct packed {
        logic [15:0]             compare_low;
        logic [15:0]             compare_high;
        logic                    modulating;
        logic                    faulty;
        logic                    accepted;
        logic [LEVEL_W_DEF-1:0]  fifo_level;
    } compare_pair_t;

    // Register copies
    logic [15:0] period_r;
    logic [15:0] duty_r;
    logic [7:0]  gain_r;
    logic [3:0]  shift_r;

    // Engine state
    logic [7:0]             sample_mem [FIFO_DEPTH_DEF];
    logic [PTR_W-1:0]       wr_ptr;
    logic [PTR_W-1:0]       rd_ptr;
    logic [LEVEL_W_DEF-1:0] level;
    logic [7:0]             flags;
    logic                   playing;
    logic [15:0]            held_lo;
    logic [15:0]            held_hi;

    compare_pair_t pair_q[$];

    function automatic logic [15:0] thresh_level();
        logic [32:0] prod;
        prod = 33'(period_r) * 33'(duty_r) + 33'(ROUND_ADD);
        return 16'(prod >> THR_SHIFT);
    endfunction

    function automatic void hold_thresh();
        held_lo = thresh_level();
        held_hi = period_r - held_lo;
    endfunction

    function automatic void hold_scaled(logic [7:0] sample_byte);
        int center;
        int scaled;
        int s;
        int ceiling;
        center  = int'(thresh_level()) - ((CENTER_BYTE * int'(gain_r)) >> shift_r);
        scaled  = (int'(sample_byte) * int'(gain_r)) >> shift_r;
        s       = scaled + center;
        ceiling = int'(period_r >> 1);
        if (s < 0)
            s = 0;
        else if (s > ceiling)
            s = ceiling;
        held_lo = 16'(s);
        held_hi = period_r - 16'(s);
    endfunction

    function automatic compare_pair_t predict_pair(logic [1:0] act, logic [7:0] smp,
                                                   logic [7:0] bits);
        compare_pair_t r;
        logic          was_faulty;
        logic [15:0]   thr;
        r.accepted = 1'b1;
        case (act)
            ACT_WRITE:
            begin
                if (level == FIFO_DEPTH_DEF)
                begin
                    r.accepted = 1'b0;
                end
                else
                begin
                    sample_mem[wr_ptr] = smp;
                    wr_ptr  = wr_ptr + 1'b1;
                    level   = level + 1'b1;
                    playing = 1'b1;
                end
            end
            ACT_TICK:
            begin
                if (level != 0)
                begin
                    hold_scaled(sample_mem[rd_ptr]);
                    rd_ptr  = rd_ptr + 1'b1;
                    level   = level - 1'b1;
                    playing = 1'b1;
                end
                else
                begin
                    playing = 1'b0;
                    hold_thresh();
                end
            end
            ACT_SET:
            begin
                flags = flags | bits;
            end
            ACT_CLEAR:
            begin
                was_faulty = (flags != 0);
                flags = flags & ~bits;
                // Last flag gone: restart from the threshold pair
                if (was_faulty && flags == 0)
                    hold_thresh();
            end
            default: ;
        endcase
        thr = thresh_level();
        if (flags != 0)
        begin
            r.compare_low  = '0;
            r.compare_high = '0;
        end
        else if (playing)
        begin
            r.compare_low  = held_lo;
            r.compare_high = held_hi;
        end
        else
        begin
            r.compare_low  = thr;
            r.compare_high = period_r - thr;
        end
        r.modulating = playing;
        r.faulty     = (flags != 0);
        r.fifo_level = level;
        return r;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        compare_pair_t want;
        if (!rst_n)
        begin
            period_r = PERIOD_RST;
            duty_r   = DUTY_RST;
            gain_r   = MULT_RST;
            shift_r  = SHIFT_RST;
            wr_ptr   = '0;
            rd_ptr   = '0;
            level    = '0;
            flags    = '0;
            playing  = 1'b0;
            held_lo  = '0;
            held_hi  = '0;
            pair_q.delete();
            errors   = 0;
            checked  = 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_PERIOD: period_r = pwdata[15:0];
                    REG_DUTY:   duty_r   = pwdata[15:0];
                    REG_MULT:   gain_r   = pwdata[7:0];
                    REG_SHIFT:  shift_r  = pwdata[3:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                pair_q.push_back(predict_pair(in_ch.action, in_ch.sample, in_ch.fault_bits));
            if (out_ch.valid && out_ch.ready)
            begin
                if (pair_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got compare_low %0d",
                             $time, out_ch.compare_low);
                end
                else
                begin
                    want = pair_q.pop_front();
                    check_field("compare_low", want.compare_low, out_ch.compare_low);
                    check_field("compare_high", want.compare_high, out_ch.compare_high);
                    check_field("modulating", 16'(want.modulating), 16'(out_ch.modulating));
                    check_field("faulty", 16'(want.faulty), 16'(out_ch.faulty));
                    check_field("accepted", 16'(want.accepted), 16'(out_ch.accepted));
                    check_field("fifo_level", 16'(want.fifo_level), 16'(out_ch.fifo_level));
                    checked++;
                end
            end
            pending <= pair_q.size();
        end
    end

endmodule

[verif/modulated_pwm_compare_engine_top_test.sv]
// Stimulus and verdict for the modulated PWM compare engine
`timescale 1ns / 1ps

module modulated_pwm_compare_engine_top_test import mpwm_pkg::*;;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 155;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    bit calm;
    bit hold_off;
    int errors;
    int pending;
    int checked;
    int n_writes;
    int n_ticks;
    int n_faults;
    int n_settings;

    mpwm_in_if  in_ch ();
    mpwm_out_if out_ch ();

    modulated_pwm_compare_engine_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    mpwm_compare_checker pair_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .pready  (pready),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending),
        .checked (checked)
    );

    always #2 clk = ~clk;

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_request(logic [1:0] act, logic [7:0] smp, logic [7:0] bits);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.action     <= act;
        in_ch.sample     <= smp;
        in_ch.fault_bits <= bits;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        case (act)
            ACT_WRITE: n_writes++;
            ACT_TICK:  n_ticks++;
            default:   n_faults++;
        endcase
    endtask

    // Drop valid and hold until every request has its result
    task automatic wait_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
    endtask

    task automatic set_config(logic [15:0] period, logic [15:0] duty, logic [7:0] gain,
                              logic [3:0] shift_amt);
        wait_results();
        reg_write(REG_PERIOD, DATA_W'(period));
        reg_write(REG_DUTY, DATA_W'(duty));
        reg_write(REG_MULT, DATA_W'(gain));
        reg_write(REG_SHIFT, DATA_W'(shift_amt));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // Threshold and center settle after the last write
        repeat (SETTLE_CYCLES) @(posedge clk);
        n_settings++;
    endtask

    task automatic random_items(int count);
        int left;
        int burst;
        int k;
        int r;
        logic [7:0] mask;
        left = count;
        while (left > 0)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                // Burst of samples, then a run of ticks that may overrun into empty
                burst = $urandom_range(1, 6);
                for (k = 0; k < burst && left > 0; k++)
                begin
                    push_request(ACT_WRITE, 8'($urandom), 8'($urandom));
                    left--;
                end
                burst = $urandom_range(0, burst + 2);
                for (k = 0; k < burst && left > 0; k++)
                begin
                    push_request(ACT_TICK, 8'($urandom), 8'($urandom));
                    left--;
                end
            end
            else if (r < 85)
            begin
                mask = ($urandom_range(0, 1) == 0) ? (8'd1 << $urandom_range(0, 7))
                                                    : 8'($urandom);
                push_request(ACT_SET, 8'($urandom), mask);
                left--;
                if (left > 0)
                begin
                    push_request(ACT_CLEAR, 8'($urandom),
                                 ($urandom_range(0, 2) == 0) ? 8'($urandom) : mask);
                    left--;
                end
            end
            else
            begin
                push_request(2'($urandom), 8'($urandom), 8'($urandom));
                left--;
            end
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        int run;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            else
            begin
                stall = pick_gap();
                if (stall > 0)
                begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            out_ch.ready <= 1'b1;
            run = calm ? 16 : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
        end
    end

    initial
    begin
        int ph;
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.action     = ACT_WRITE;
        in_ch.sample     = '0;
        in_ch.fault_bits = '0;
        calm             = 1'b0;
        hold_off         = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: clamps, faults over playback, empty ticks
        push_request(ACT_TICK, 8'h00, 8'h00);
        set_config(16'd1000, 16'hFFFF, 8'hFF, 4'd0);
        push_request(ACT_WRITE, 8'h00, 8'hFF);
        push_request(ACT_WRITE, 8'hFF, 8'h00);
        push_request(ACT_WRITE, 8'h7F, 8'h00);
        push_request(ACT_WRITE, 8'h80, 8'h00);
        push_request(ACT_TICK, 8'hAA, 8'h55);
        push_request(ACT_TICK, 8'h55, 8'hAA);
        push_request(ACT_SET, 8'h00, 8'h81);
        push_request(ACT_TICK, 8'hFF, 8'hFF);
        push_request(ACT_CLEAR, 8'h00, 8'h01);
        push_request(ACT_CLEAR, 8'h00, 8'h80);
        push_request(ACT_TICK, 8'h00, 8'h00);
        push_request(ACT_TICK, 8'h00, 8'h00);
        push_request(ACT_SET, 8'hFF, 8'hFF);
        push_request(ACT_WRITE, 8'h55, 8'h00);
        push_request(ACT_CLEAR, 8'h00, 8'h00);
        push_request(ACT_CLEAR, 8'h00, 8'hFF);
        push_request(ACT_TICK, 8'h00, 8'h00);
        push_request(ACT_TICK, 8'h00, 8'h00);
        push_request(ACT_SET, 8'h00, 8'h00);
        push_request(ACT_CLEAR, 8'h00, 8'h00);

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: set_config(16'hFFFF, 16'hFFFF, 8'hFF, 4'd0);
                1: set_config(16'd1, 16'hFFFF, 8'd0, 4'd15);
                2: set_config(16'd0, 16'($urandom), 8'($urandom), 4'($urandom));
                3: set_config(16'hFFFF, 16'd0, 8'hFF, 4'd15);
                4: set_config(PERIOD_RST, DUTY_RST, MULT_RST, SHIFT_RST);
                default: set_config(16'($urandom_range(1, 65535)), 16'($urandom),
                                    8'($urandom), 4'($urandom));
            endcase
            // Back-pressure: result side stops while requests keep coming
            if (ph == 0)
                hold_off = 1'b1;
            calm = (ph == 3);
            random_items(PHASE_ITEMS);
            calm = 1'b0;
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Drove %0d requests: %0d sample writes, %0d ticks, %0d fault updates",
                 n_writes + n_ticks + n_faults, n_writes, n_ticks, n_faults);
        $display("Checked %0d results over %0d register settings, %0d still outstanding",
                 checked, n_settings, pending);
        if (errors == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("Run timed out with %0d results outstanding", pending);
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/mpwm_pkg.sv
sv/mpwm_if.sv
sv/mpwm_fifo.sv
sv/modulated_pwm_compare_engine_top.sv
verif/mpwm_compare_checker.sv
verif/modulated_pwm_compare_engine_top_test.sv
